>>> hw/rtl/ryc_pkg.sv
// package: shared constants, tables and types of the rousselier yield check
package ryc_pkg;

	localparam int QBITS        = 23;
	localparam int TERMS        = 12;
	localparam int RECIP_SH     = 34;
	localparam int ROOT_STEPS   = 16;
	localparam int FRONT_STAGES = 2;
	localparam int DIV_STAGES   = QBITS + 1;
	localparam int EXP_STAGES   = 3 * TERMS + 4;
	localparam int ROOT_STAGES  = ROOT_STEPS + 4;
	localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + EXP_STAGES + ROOT_STAGES;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [22:0] X_MAX_Q16 = 23'd1441792;
	localparam logic [22:0] X_MIN_Q16 = 23'd2949120;
	localparam logic [40:0] P_CAP     = 41'h100_0000_0000;

	localparam logic [23:0] DAMAGE_RESET    = 24'd131072;
	localparam logic [30:0] REFERENCE_RESET = 31'd128000;

	// floor(2^34 / k) for k = 1..12, k = 1 kept one below 2^34
	localparam logic [33:0] RECIP [TERMS] = '{
		34'd17179869183, 34'd8589934592, 34'd5726623061, 34'd4294967296,
		34'd3435973836,  34'd2863311530, 34'd2454267026, 34'd2147483648,
		34'd1908874353,  34'd1717986918, 34'd1561806289, 34'd1431655765
	};

	typedef enum logic [0:0] {
		REG_DAMAGE = 1'b0,
		REG_REF    = 1'b1
	} ryc_reg_t;

	typedef struct packed {
		logic [30:0] eqv;
		logic [30:0] term1;
		logic [39:0] b;
	} ryc_side_t;

endpackage

>>> hw/rtl/rousselier_yield_check.sv
// top level: rousselier yield check, configuration registers and pipeline
// A fully pipelined evaluator: one material point may be started in every clock cycle and busy
// stays low. Each request returns its result on the output ports, marked
// by a one-cycle done strobe, in request order; the depth comes from a 2-stage front end, a
// 24-stage bit-per-stage divider for the exponent, 40 stages for the exponential (3 per series
// term) and 20 for the stress product and a 16-stage square root. Results cannot be held off,
// so the receiver must take done whenever it rises. Configuration writes take effect at once
// and belong in times when no request is in flight.
module rousselier_yield_check
	import ryc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [30:0]        equivalent_stress,
	input  logic [30:0]        matrix_flow_stress,
	input  logic signed [31:0] stress_trace,
	input  logic [15:0]        void_fraction,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_addr,
	input  logic [30:0]        cfg_wdata,
	output logic               done,
	output logic signed [31:0] yield_value,
	output logic [23:0]        root_flow_stress,
	output logic               negative_root_flag,
	output logic               overflow_flag
);

	logic [23:0] damage_q;
	logic [30:0] reference_q;

	logic        fr_valid;
	ryc_side_t   fr_side;
	logic [49:0] fr_den;
	logic [31:0] fr_mag;
	logic        fr_neg;

	logic             dv_valid;
	ryc_side_t        dv_side;
	logic             dv_neg;
	logic             dv_sat;
	logic [QBITS-1:0] dv_xmag;

	logic        ex_valid;
	ryc_side_t   ex_side;
	logic [63:0] ex_e;
	logic        ex_ovf;

	logic [31:0] rt_phi;
	logic [15:0] rt_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damage_q    <= DAMAGE_RESET;
			reference_q <= REFERENCE_RESET;
		end else if (cfg_we) begin
			case (ryc_reg_t'(cfg_addr))
				REG_DAMAGE: damage_q    <= cfg_wdata[23:0];
				REG_REF:    reference_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	ryc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.eqv        (equivalent_stress),
		.flow       (matrix_flow_stress),
		.trace      (stress_trace),
		.frac       (void_fraction),
		.damage     (damage_q),
		.ref_stress (reference_q),
		.out_valid  (fr_valid),
		.out_side   (fr_side),
		.out_den    (fr_den),
		.out_mag    (fr_mag),
		.out_neg    (fr_neg)
	);

	ryc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_side   (fr_side),
		.in_den    (fr_den),
		.in_mag    (fr_mag),
		.in_neg    (fr_neg),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_neg   (dv_neg),
		.out_sat   (dv_sat),
		.out_xmag  (dv_xmag)
	);

	ryc_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_side   (dv_side),
		.in_neg    (dv_neg),
		.in_sat    (dv_sat),
		.in_xmag   (dv_xmag),
		.out_valid (ex_valid),
		.out_side  (ex_side),
		.out_e     (ex_e),
		.out_ovf   (ex_ovf)
	);

	ryc_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ex_valid),
		.in_side   (ex_side),
		.in_e      (ex_e),
		.in_ovf    (ex_ovf),
		.out_valid (done),
		.out_phi   (rt_phi),
		.out_root  (rt_root),
		.out_neg   (negative_root_flag),
		.out_ovf   (overflow_flag)
	);

	assign yield_value      = rt_phi;
	assign root_flow_stress = {8'd0, rt_root};

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request did not complete on time");

	a_neg_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && negative_root_flag |-> root_flow_stress == '0)
		else $error("root not forced to zero");

	a_neg_yield_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && negative_root_flag |-> yield_value > 32'sd0)
		else $error("negative porous stress with non-positive yield value");

endmodule

>>> hw/rtl/ryc_front.sv
// front stages: porosity products, damage scale and exponent denominator
module ryc_front
	import ryc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [30:0] eqv,
	input  logic [30:0] flow,
	input  logic [31:0] trace,
	input  logic [15:0] frac,
	input  logic [23:0] damage,
	input  logic [30:0] ref_stress,
	output logic        out_valid,
	output ryc_side_t   out_side,
	output logic [49:0] out_den,
	output logic [31:0] out_mag,
	output logic        out_neg
);

	logic [16:0] omf;
	logic [30:0] s1;
	logic [31:0] mag;
	logic [55:0] bprod;

	logic        v_s1;
	logic [30:0] eqv_s1;
	logic [47:0] t1_s1;
	logic [47:0] os_s1;
	logic [54:0] ds_s1;
	logic [32:0] fo_s1;
	logic [31:0] mag_s1;
	logic        neg_s1;

	logic        v_s2;
	ryc_side_t   side_s2;
	logic [49:0] den_s2;
	logic [31:0] mag_s2;
	logic        neg_s2;

	assign omf   = 17'h10000 - {1'b0, frac};
	assign s1    = (ref_stress == '0) ? 31'd1 : ref_stress;
	assign mag   = trace[31] ? (32'd0 - trace) : trace;
	assign bprod = 56'(ds_s1[54:16]) * 56'(fo_s1[32:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		eqv_s1        <= eqv;
		t1_s1         <= 48'(omf) * 48'(flow);
		os_s1         <= 48'(omf) * 48'(s1);
		ds_s1         <= 55'(damage) * 55'(s1);
		fo_s1         <= 33'(frac) * 33'(omf);
		mag_s1        <= mag;
		neg_s1        <= trace[31];
		side_s2.eqv   <= eqv_s1;
		side_s2.term1 <= t1_s1[46:16];
		side_s2.b     <= bprod[55:16];
		den_s2        <= 50'({os_s1, 1'b0}) + 50'(os_s1);
		mag_s2        <= mag_s1;
		neg_s2        <= neg_s1;
	end

	assign out_valid = v_s2;
	assign out_side  = side_s2;
	assign out_den   = den_s2;
	assign out_mag   = mag_s2;
	assign out_neg   = neg_s2;

endmodule

>>> hw/rtl/ryc_div.sv
// restoring divider for the exponent, one quotient bit per stage
module ryc_div
	import ryc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ryc_side_t        in_side,
	input  logic [49:0]      in_den,
	input  logic [31:0]      in_mag,
	input  logic             in_neg,
	output logic             out_valid,
	output ryc_side_t        out_side,
	output logic             out_neg,
	output logic             out_sat,
	output logic [QBITS-1:0] out_xmag
);

	logic [QBITS:0]   v_s;
	logic [63:0]      rem_s  [QBITS+1];
	logic [QBITS-1:0] quo_s  [QBITS+1];
	logic [49:0]      den_s  [QBITS+1];
	ryc_side_t        side_s [QBITS+1];
	logic             neg_s  [QBITS+1];
	logic             sat_s  [QBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[QBITS-1:0], in_valid};
		end
	end

	// quotient too large for the kept bits
	always_ff @(posedge clk) begin
		rem_s[0]  <= {in_mag, 32'd0};
		quo_s[0]  <= '0;
		den_s[0]  <= in_den;
		side_s[0] <= in_side;
		neg_s[0]  <= in_neg;
		sat_s[0]  <= 50'({in_mag, 9'd0}) >= in_den;
	end

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		localparam int BIT = QBITS - j;
		localparam logic [QBITS-1:0] MASK = QBITS'(1) << BIT;
		logic [72:0] sub;
		logic [72:0] rem_x;
		logic        take;

		assign sub   = 73'(den_s[j-1]) << BIT;
		assign rem_x = 73'(rem_s[j-1]);
		assign take  = rem_x >= sub;

		always_ff @(posedge clk) begin
			rem_s[j]  <= take ? 64'(rem_x - sub) : rem_s[j-1];
			quo_s[j]  <= take ? (quo_s[j-1] | MASK) : quo_s[j-1];
			den_s[j]  <= den_s[j-1];
			side_s[j] <= side_s[j-1];
			neg_s[j]  <= neg_s[j-1];
			sat_s[j]  <= sat_s[j-1];
		end
	end

	assign out_valid = v_s[QBITS];
	assign out_side  = side_s[QBITS];
	assign out_neg   = neg_s[QBITS];
	assign out_sat   = sat_s[QBITS];
	assign out_xmag  = quo_s[QBITS];

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(QBITS + 1) out_valid)
		else $error("divider lost a request");

endmodule

>>> hw/rtl/ryc_exp.sv
// exponential: range split, taylor series of the fraction, final shift
module ryc_exp
	import ryc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  ryc_side_t        in_side,
	input  logic             in_neg,
	input  logic             in_sat,
	input  logic [QBITS-1:0] in_xmag,
	output logic             out_valid,
	output ryc_side_t        out_side,
	output logic [63:0]      out_e,
	output logic             out_ovf
);

	typedef struct packed {
		ryc_side_t   side;
		logic        pos_ovf;
		logic        zero;
		logic        neg;
		logic [8:0]  sh;
		logic [31:0] r;
		logic [33:0] sum;
	} ctl_t;

	logic [EXP_STAGES-1:0] v_s;

	ctl_t        ctl_s1;
	logic [23:0] ymag_s1;
	ctl_t        ctl_s2;
	logic [15:0] fr_s2;

	logic [8:0]  c_up;
	logic [24:0] c_ext;
	ctl_t        ctl_s2_d;
	ctl_t        ctl_c0_d;

	ctl_t        ctl_a  [TERMS];
	logic [31:0] t_a    [TERMS];
	ctl_t        ctl_b  [TERMS];
	logic [31:0] t_b    [TERMS];
	logic [31:0] q0_b   [TERMS];
	ctl_t        ctl_c  [TERMS+1];
	logic [32:0] term_c [TERMS+1];

	ryc_side_t   side_f;
	logic [63:0] e_f;
	logic        ovf_f;
	logic [63:0] e_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[EXP_STAGES-2:0], in_valid};
		end
	end

	assign c_up  = 9'((25'(ymag_s1) + 25'd65535) >> 16);
	assign c_ext = {c_up, 16'd0};

	always_comb begin
		ctl_s2_d    = ctl_s1;
		ctl_s2_d.sh = ctl_s1.neg ? c_up : {1'b0, ymag_s1[23:16]};
	end

	always_comb begin
		ctl_c0_d     = ctl_s2;
		ctl_c0_d.r   = 32'((48'(fr_s2) * 48'(LN2_Q32)) >> 16);
		ctl_c0_d.sum = 34'h1_0000_0000;
	end

	always_ff @(posedge clk) begin
		ctl_s1.side    <= in_side;
		ctl_s1.neg     <= in_neg;
		ctl_s1.pos_ovf <= !in_neg && (in_sat || in_xmag > X_MAX_Q16);
		ctl_s1.zero    <= in_neg && (in_sat || in_xmag > X_MIN_Q16);
		ctl_s1.sh      <= '0;
		ctl_s1.r       <= '0;
		ctl_s1.sum     <= '0;
		ymag_s1        <= 24'((54'(in_xmag) * 54'(LOG2E_Q30)) >> 30);

		ctl_s2 <= ctl_s2_d;
		if (ctl_s1.neg) begin
			fr_s2 <= 16'(c_ext - 25'(ymag_s1));
		end else begin
			fr_s2 <= ymag_s1[15:0];
		end

		ctl_c[0]  <= ctl_c0_d;
		term_c[0] <= 33'h1_0000_0000;
	end

	for (genvar i = 0; i < TERMS; i++) begin : g_term
		localparam logic [3:0] K = 4'(i + 1);
		logic [65:0] pm;
		logic [35:0] back;
		logic [35:0] rem;
		logic [31:0] qk;
		ctl_t        nxt;

		assign pm   = 66'(t_a[i]) * 66'(RECIP[i]);
		assign back = 36'(q0_b[i]) * 36'(K);
		assign rem  = 36'(t_b[i]) - back;
		assign qk   = (rem >= 36'(K)) ? (q0_b[i] + 32'd1) : q0_b[i];

		always_comb begin
			nxt     = ctl_b[i];
			nxt.sum = ctl_b[i].sum + 34'(qk);
		end

		always_ff @(posedge clk) begin
			ctl_a[i] <= ctl_c[i];
			t_a[i]   <= 32'((65'(term_c[i]) * 65'(ctl_c[i].r)) >> 32);

			ctl_b[i] <= ctl_a[i];
			t_b[i]   <= t_a[i];
			q0_b[i]  <= pm[65:RECIP_SH];

			ctl_c[i+1]  <= nxt;
			term_c[i+1] <= 33'(qk);
		end
	end

	always_comb begin
		if (ctl_c[TERMS].pos_ovf) begin
			e_next = '1;
		end else if (ctl_c[TERMS].zero) begin
			e_next = '0;
		end else if (!ctl_c[TERMS].neg) begin
			e_next = 64'(ctl_c[TERMS].sum) << ctl_c[TERMS].sh[5:0];
		end else if (ctl_c[TERMS].sh >= 9'd64) begin
			e_next = '0;
		end else begin
			e_next = 64'(ctl_c[TERMS].sum) >> ctl_c[TERMS].sh[5:0];
		end
	end

	always_ff @(posedge clk) begin
		side_f <= ctl_c[TERMS].side;
		e_f    <= e_next;
		ovf_f  <= ctl_c[TERMS].pos_ovf;
	end

	assign out_valid = v_s[EXP_STAGES-1];
	assign out_side  = side_f;
	assign out_e     = e_f;
	assign out_ovf   = ovf_f;

endmodule

>>> hw/rtl/ryc_root.sv
// porous stress product, yield value and pipelined integer square root
module ryc_root
	import ryc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  ryc_side_t   in_side,
	input  logic [63:0] in_e,
	input  logic        in_ovf,
	output logic        out_valid,
	output logic [31:0] out_phi,
	output logic [15:0] out_root,
	output logic        out_neg,
	output logic        out_ovf
);

	logic [ROOT_STAGES-1:0] v_s;

	logic [30:0] eqv_s1;
	logic [30:0] t1_s1;
	logic        ovf_s1;
	logic [63:0] m_ll_s1;
	logic [63:0] m_lh_s1;
	logic [39:0] m_hh_s1;
	logic [39:0] m_hl_s1;

	logic [73:0] psum;
	logic [30:0] eqv_s2;
	logic [30:0] t1_s2;
	logic        ovf_s2;
	logic [40:0] p_s2;

	logic [30:0]        eqv_s3;
	logic               ovf_s3;
	logic signed [41:0] sig_s3;

	logic signed [42:0] phi_w;
	logic [32:0]        arg3;

	logic [31:0] rv_s  [ROOT_STEPS+1];
	logic [31:0] rr_s  [ROOT_STEPS+1];
	logic [31:0] phi_s [ROOT_STEPS+1];
	logic        neg_s [ROOT_STEPS+1];
	logic        ovf_s [ROOT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[ROOT_STAGES-2:0], in_valid};
		end
	end

	assign psum = 74'(m_lh_s1) + (74'(m_hh_s1) << 32) + 74'(m_hl_s1) + 74'(m_ll_s1[63:32]);
	assign phi_w = $signed({12'd0, eqv_s3}) - $signed({sig_s3[41], sig_s3});
	assign arg3  = 33'({sig_s3[30:0], 1'b0}) + 33'(sig_s3[30:0]);

	always_ff @(posedge clk) begin
		eqv_s1  <= in_side.eqv;
		t1_s1   <= in_side.term1;
		ovf_s1  <= in_ovf;
		m_ll_s1 <= 64'(in_side.b[31:0]) * 64'(in_e[31:0]);
		m_lh_s1 <= 64'(in_side.b[31:0]) * 64'(in_e[63:32]);
		m_hh_s1 <= 40'(in_side.b[39:32]) * 40'(in_e[63:32]);
		m_hl_s1 <= 40'(in_side.b[39:32]) * 40'(in_e[31:0]);

		eqv_s2 <= eqv_s1;
		t1_s2  <= t1_s1;
		ovf_s2 <= ovf_s1;
		p_s2   <= (psum > 74'(P_CAP)) ? P_CAP : psum[40:0];

		eqv_s3 <= eqv_s2;
		ovf_s3 <= ovf_s2;
		sig_s3 <= $signed({11'd0, t1_s2}) - $signed({1'b0, p_s2});

		// clamp on the high side only, the low side cannot be reached
		if (phi_w > 43'sd2147483647) begin
			phi_s[0] <= 32'h7FFF_FFFF;
			ovf_s[0] <= 1'b1;
		end else begin
			phi_s[0] <= phi_w[31:0];
			ovf_s[0] <= ovf_s3;
		end
		neg_s[0] <= sig_s3[41];
		rv_s[0]  <= sig_s3[41] ? 32'd0 : arg3[32:1];
		rr_s[0]  <= '0;
	end

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_sqrt
		localparam logic [31:0] BIT = 32'd1 << (2 * (ROOT_STEPS - 1 - j));
		logic [31:0] trial;
		logic        take;

		assign trial = rr_s[j] + BIT;
		assign take  = rv_s[j] >= trial;

		always_ff @(posedge clk) begin
			rv_s[j+1]  <= take ? (rv_s[j] - trial) : rv_s[j];
			rr_s[j+1]  <= take ? ((rr_s[j] >> 1) + BIT) : (rr_s[j] >> 1);
			phi_s[j+1] <= phi_s[j];
			neg_s[j+1] <= neg_s[j];
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	assign out_valid = v_s[ROOT_STAGES-1];
	assign out_phi   = phi_s[ROOT_STEPS];
	assign out_root  = rr_s[ROOT_STEPS][15:0];
	assign out_neg   = neg_s[ROOT_STEPS];
	assign out_ovf   = ovf_s[ROOT_STEPS];

endmodule
